/* rtl/cpt_pkg.sv */
// ----------------------------------------------------------------------------
// cpt_pkg
// Widths, types and region codes shared by the closest-point pipeline.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int COORD_BITS = 16;
  localparam int DW   = COORD_BITS + 1;      // vertex differences
  localparam int PW   = 2 * DW;              // one coordinate product
  localparam int DOTW = PW + 2;              // dot products
  localparam int XLO  = DOTW / 2;            // low split of cross products
  localparam int XPW  = DOTW + XLO + 1;      // cross partial product
  localparam int VW   = 2 * DOTW;            // barycentric terms
  localparam int DENW = VW + 2;              // denominators and weights
  localparam int MCH  = (DENW + 2) / 3;      // weight chunk
  localparam int PPW  = DW + MCH + 1;        // weight partial product
  localparam int NUMW = DENW + DW + 2;       // numerators
  localparam int NW   = NUMW + 2;            // divider remainder
  localparam int DDW  = DENW + 2;            // divider divisor
  localparam int QB   = COORD_BITS + 1;      // quotient bits

  typedef logic signed [COORD_BITS-1:0] crd_t;
  typedef logic signed [DW-1:0]         dif_t;
  typedef logic signed [PW-1:0]         prd_t;
  typedef logic signed [DOTW-1:0]       dot_t;
  typedef logic signed [XPW-1:0]        xp_t;
  typedef logic signed [VW-1:0]         v_t;
  typedef logic signed [DENW-1:0]       den_t;
  typedef logic signed [PPW-1:0]        pp_t;
  typedef logic signed [NUMW-1:0]       num_t;

  typedef enum logic [2:0] {
    REG_VA   = 3'd0,
    REG_VB   = 3'd1,
    REG_VC   = 3'd2,
    REG_AB   = 3'd3,
    REG_AC   = 3'd4,
    REG_BC   = 3'd5,
    REG_FACE = 3'd6
  } region_e;

endpackage

/* rtl/closest_point_on_triangle.sv */
// ----------------------------------------------------------------------------
// closest_point_on_triangle
// Closest point of a triangle to a query point by Voronoi-region tests,
// exact integer dot products and one rounded division per coordinate.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+------------------
//   query    | query_*_i, vert_{a,b,c}_*_i             | start_i, busy_o
//   result   | near_*_o, region_o                      | done_o strobe
//
// One query per cycle; busy_o stays low.
// A query passes through ten arithmetic stages, divider stages resolving one
// quotient bit each, and the output register.
// Reset clears only the valid bits; data registers are not reset.
// Results appear on done_o for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module closest_point_on_triangle (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  cpt_pkg::crd_t query_x_i,
  input  cpt_pkg::crd_t query_y_i,
  input  cpt_pkg::crd_t query_z_i,
  input  cpt_pkg::crd_t vert_a_x_i,
  input  cpt_pkg::crd_t vert_a_y_i,
  input  cpt_pkg::crd_t vert_a_z_i,
  input  cpt_pkg::crd_t vert_b_x_i,
  input  cpt_pkg::crd_t vert_b_y_i,
  input  cpt_pkg::crd_t vert_b_z_i,
  input  cpt_pkg::crd_t vert_c_x_i,
  input  cpt_pkg::crd_t vert_c_y_i,
  input  cpt_pkg::crd_t vert_c_z_i,
  output logic          done_o,
  output cpt_pkg::crd_t near_x_o,
  output cpt_pkg::crd_t near_y_o,
  output cpt_pkg::crd_t near_z_o,
  output logic [2:0]    region_o
);
  import cpt_pkg::*;

  localparam int SL = QB + 6;
  localparam int XI [6] = '{0, 2, 4, 0, 2, 4};
  localparam int YI [6] = '{3, 1, 1, 5, 5, 3};

  typedef struct {
    crd_t a  [3];
    crd_t b  [3];
    crd_t c  [3];
    dif_t ab [3];
    dif_t ac [3];
    dif_t bc [3];
  } geo_t;

  typedef struct packed {
    region_e                     region;
    logic                        use_div;
    logic [2:0][COORD_BITS-1:0]  fb;
  } side_t;

  typedef logic signed [DOTW:0] dx_t;

  crd_t  p_w [3];
  crd_t  a_w [3];
  crd_t  b_w [3];
  crd_t  c_w [3];

  logic [10:1] v_q;
  logic [10:1] v_d;
  geo_t  geo_q [1:6];
  dif_t  ap_q [3];
  dif_t  bp_q [3];
  dif_t  cp_q [3];
  prd_t  pr_q [6][3];
  dot_t  dd_q [3:6][6];
  xp_t   xl_q [6];
  xp_t   xh_q [6];
  v_t    pp_q [6];
  v_t    vv_q [3];

  dx_t     e_w, g_w, dab_w, dac_w;
  den_t    dbc_w, dface_w;
  logic    f_va, f_vb, f_ab, f_vc, f_ac, f_bc;
  region_e reg_w;
  den_t    den_w, w1_w, w2_w;
  dif_t    base_w [3];
  dif_t    e1_w [3];
  dif_t    e2_w [3];
  crd_t    fb_w [3];

  den_t  den7_q, w1_q, w2_q, den8_q, den9_q, den10_q;
  dif_t  base_q [3];
  dif_t  e1_q [3];
  dif_t  e2_q [3];
  side_t side_q [SL];
  dif_t  xop_w [3][3];
  den_t  wop_w [3];
  pp_t   pt_q [3][3][3];
  num_t  tm_q [3][3];
  num_t  num_q [3];

  logic  dv_w [3];
  crd_t  quo_w [3];
  logic  done_q;
  crd_t  near_q [3];
  logic [2:0] region_q;

  assign busy_o = 1'b0;

  assign p_w[0] = query_x_i;  assign p_w[1] = query_y_i;  assign p_w[2] = query_z_i;
  assign a_w[0] = vert_a_x_i; assign a_w[1] = vert_a_y_i; assign a_w[2] = vert_a_z_i;
  assign b_w[0] = vert_b_x_i; assign b_w[1] = vert_b_y_i; assign b_w[2] = vert_b_z_i;
  assign c_w[0] = vert_c_x_i; assign c_w[1] = vert_c_y_i; assign c_w[2] = vert_c_z_i;

  assign v_d = {v_q[9:1], start_i && !busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      done_q <= 1'b0;
    end else begin
      v_q    <= v_d;
      done_q <= dv_w[0];
    end
  end

  // stages 1 to 6: differences, dot products, cross terms
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      geo_q[1].a[i]  <= a_w[i];
      geo_q[1].b[i]  <= b_w[i];
      geo_q[1].c[i]  <= c_w[i];
      geo_q[1].ab[i] <= dif_t'(b_w[i]) - dif_t'(a_w[i]);
      geo_q[1].ac[i] <= dif_t'(c_w[i]) - dif_t'(a_w[i]);
      geo_q[1].bc[i] <= dif_t'(c_w[i]) - dif_t'(b_w[i]);
      ap_q[i] <= dif_t'(p_w[i]) - dif_t'(a_w[i]);
      bp_q[i] <= dif_t'(p_w[i]) - dif_t'(b_w[i]);
      cp_q[i] <= dif_t'(p_w[i]) - dif_t'(c_w[i]);
    end
    for (int k = 2; k <= 6; k++) geo_q[k] <= geo_q[k-1];

    for (int i = 0; i < 3; i++) begin
      pr_q[0][i] <= geo_q[1].ab[i] * ap_q[i];
      pr_q[1][i] <= geo_q[1].ac[i] * ap_q[i];
      pr_q[2][i] <= geo_q[1].ab[i] * bp_q[i];
      pr_q[3][i] <= geo_q[1].ac[i] * bp_q[i];
      pr_q[4][i] <= geo_q[1].ab[i] * cp_q[i];
      pr_q[5][i] <= geo_q[1].ac[i] * cp_q[i];
    end

    for (int j = 0; j < 6; j++) begin
      dd_q[3][j] <= dot_t'(pr_q[j][0]) + dot_t'(pr_q[j][1]) + dot_t'(pr_q[j][2]);
    end
    for (int k = 4; k <= 6; k++) dd_q[k] <= dd_q[k-1];

    for (int j = 0; j < 6; j++) begin
      xl_q[j] <= dd_q[3][XI[j]] * $signed({1'b0, dd_q[3][YI[j]][XLO-1:0]});
      xh_q[j] <= dd_q[3][XI[j]] * $signed(dd_q[3][YI[j]][DOTW-1:XLO]);
    end

    for (int j = 0; j < 6; j++) begin
      pp_q[j] <= (v_t'(xh_q[j]) <<< XLO) + v_t'(xl_q[j]);
    end

    vv_q[0] <= pp_q[4] - pp_q[5];
    vv_q[1] <= pp_q[2] - pp_q[3];
    vv_q[2] <= pp_q[0] - pp_q[1];
  end

  // stage 7: region tests and operand select
  always_comb begin
    e_w     = dx_t'(dd_q[6][3]) - dx_t'(dd_q[6][2]);
    g_w     = dx_t'(dd_q[6][4]) - dx_t'(dd_q[6][5]);
    dab_w   = dx_t'(dd_q[6][0]) - dx_t'(dd_q[6][2]);
    dac_w   = dx_t'(dd_q[6][1]) - dx_t'(dd_q[6][5]);
    dbc_w   = den_t'(e_w) + den_t'(g_w);
    dface_w = den_t'(vv_q[0]) + den_t'(vv_q[1]) + den_t'(vv_q[2]);

    f_va = (dd_q[6][0] <= 0) && (dd_q[6][1] <= 0);
    f_vb = (dd_q[6][2] >= 0) && (dd_q[6][3] <= dd_q[6][2]);
    f_ab = (vv_q[2] <= 0) && (dd_q[6][0] >= 0) && (dd_q[6][2] <= 0);
    f_vc = (dd_q[6][5] >= 0) && (dd_q[6][4] <= dd_q[6][5]);
    f_ac = (vv_q[1] <= 0) && (dd_q[6][1] >= 0) && (dd_q[6][5] <= 0);
    f_bc = (vv_q[0] <= 0) && (e_w >= 0) && (g_w >= 0);

    if (f_va)      reg_w = REG_VA;
    else if (f_vb) reg_w = REG_VB;
    else if (f_ab) reg_w = REG_AB;
    else if (f_vc) reg_w = REG_VC;
    else if (f_ac) reg_w = REG_AC;
    else if (f_bc) reg_w = REG_BC;
    else           reg_w = REG_FACE;

    den_w = '0;
    w1_w  = '0;
    w2_w  = '0;
    for (int i = 0; i < 3; i++) begin
      base_w[i] = dif_t'(geo_q[6].a[i]);
      e1_w[i]   = '0;
      e2_w[i]   = '0;
      fb_w[i]   = geo_q[6].a[i];
    end

    case (reg_w)
      REG_VB: begin
        for (int i = 0; i < 3; i++) fb_w[i] = geo_q[6].b[i];
      end
      REG_VC: begin
        for (int i = 0; i < 3; i++) fb_w[i] = geo_q[6].c[i];
      end
      REG_AB: begin
        den_w = den_t'(dab_w);
        w1_w  = den_t'(dd_q[6][0]);
        for (int i = 0; i < 3; i++) e1_w[i] = geo_q[6].ab[i];
      end
      REG_AC: begin
        den_w = den_t'(dac_w);
        w1_w  = den_t'(dd_q[6][1]);
        for (int i = 0; i < 3; i++) e1_w[i] = geo_q[6].ac[i];
      end
      REG_BC: begin
        den_w = dbc_w;
        w1_w  = den_t'(e_w);
        for (int i = 0; i < 3; i++) begin
          base_w[i] = dif_t'(geo_q[6].b[i]);
          e1_w[i]   = geo_q[6].bc[i];
          fb_w[i]   = geo_q[6].b[i];
        end
      end
      REG_FACE: begin
        den_w = dface_w;
        w1_w  = den_t'(vv_q[1]);
        w2_w  = den_t'(vv_q[2]);
        for (int i = 0; i < 3; i++) begin
          e1_w[i] = geo_q[6].ab[i];
          e2_w[i] = geo_q[6].ac[i];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xop_w[i][0] = base_q[i];
      xop_w[i][1] = e1_q[i];
      xop_w[i][2] = e2_q[i];
    end
    wop_w[0] = den7_q;
    wop_w[1] = w1_q;
    wop_w[2] = w2_q;
  end

  // stages 7 to 10: weighted numerators
  always_ff @(posedge clk_i) begin
    den7_q <= den_w;
    w1_q   <= w1_w;
    w2_q   <= w2_w;
    for (int i = 0; i < 3; i++) begin
      base_q[i] <= base_w[i];
      e1_q[i]   <= e1_w[i];
      e2_q[i]   <= e2_w[i];
      side_q[0].fb[i] <= fb_w[i];
    end
    side_q[0].region  <= reg_w;
    side_q[0].use_div <= (reg_w inside {REG_AB, REG_AC, REG_BC, REG_FACE}) && (den_w != '0);
    for (int k = 1; k < SL; k++) side_q[k] <= side_q[k-1];

    for (int i = 0; i < 3; i++) begin
      for (int t = 0; t < 3; t++) begin
        pt_q[i][t][0] <= xop_w[i][t] * $signed({1'b0, wop_w[t][MCH-1:0]});
        pt_q[i][t][1] <= xop_w[i][t] * $signed({1'b0, wop_w[t][2*MCH-1:MCH]});
        pt_q[i][t][2] <= xop_w[i][t] * $signed(wop_w[t][DENW-1:2*MCH]);
      end
    end
    den8_q <= den7_q;

    for (int i = 0; i < 3; i++) begin
      for (int t = 0; t < 3; t++) begin
        tm_q[i][t] <= num_t'(pt_q[i][t][0]) + (num_t'(pt_q[i][t][1]) <<< MCH)
                    + (num_t'(pt_q[i][t][2]) <<< (2 * MCH));
      end
    end
    den9_q <= den8_q;

    for (int i = 0; i < 3; i++) num_q[i] <= tm_q[i][0] + tm_q[i][1] + tm_q[i][2];
    den10_q <= den9_q;
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    cpt_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v_q[10]),
      .num_i   (num_q[i]),
      .den_i   (den10_q),
      .valid_o (dv_w[i]),
      .quo_o   (quo_w[i])
    );
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      near_q[i] <= side_q[SL-1].use_div ? quo_w[i] : crd_t'(side_q[SL-1].fb[i]);
    end
    region_q <= side_q[SL-1].region;
  end

  assign done_o   = done_q;
  assign near_x_o = near_q[0];
  assign near_y_o = near_q[1];
  assign near_z_o = near_q[2];
  assign region_o = region_q;

`ifndef NO_ASSERTIONS
  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_w[0] == dv_w[1]) && (dv_w[0] == dv_w[2]))
    else $error("divider lanes out of step");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(QB + 13) done_o)
    else $error("result beat missing at fixed latency");

  a_vertex_no_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_w[0] && side_q[SL-1].use_div) |-> !(side_q[SL-1].region == REG_VA ||
                                            side_q[SL-1].region == REG_VB ||
                                            side_q[SL-1].region == REG_VC))
    else $error("vertex region routed through divider");
`endif

endmodule

/* rtl/cpt_div.sv */
// ----------------------------------------------------------------------------
// cpt_div
// Pipelined rounding divider: num / den, nearest, ties away from zero,
// saturated to the coordinate range. One quotient bit per stage.
// ----------------------------------------------------------------------------
module cpt_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  cpt_pkg::num_t num_i,
  input  cpt_pkg::den_t den_i,
  output logic          valid_o,
  output cpt_pkg::crd_t quo_o
);
  import cpt_pkg::*;

  logic [NUMW:0]   an_w;
  logic [DENW:0]   ad_w;
  logic [NW-1:0]   r_q   [QB];
  logic [DDW-1:0]  d_q   [QB];
  logic [QB-1:0]   q_q   [1:QB];
  logic            ng_q  [QB+1];
  logic            vl_q  [QB+1];
  logic [NW-1:0]   ds_w  [QB];
  logic            ge_w  [QB];
  logic [NW-1:0]   rn_w  [QB-1];
  logic [QB-1:0]   qf_w;
  logic            bigp_w;
  logic            bign_w;
  crd_t            quo_d;
  crd_t            quo_q;
  logic            vo_q;

  assign an_w = num_i[NUMW-1] ? ({1'b0, ~num_i} + (NUMW+1)'(1)) : {1'b0, num_i};
  assign ad_w = den_i[DENW-1] ? ({1'b0, ~den_i} + (DENW+1)'(1)) : {1'b0, den_i};

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      ds_w[k] = NW'(d_q[k]) << (QB - 1 - k);
      ge_w[k] = r_q[k] >= ds_w[k];
    end
    for (int k = 0; k < QB - 1; k++) begin
      rn_w[k] = ge_w[k] ? (r_q[k] - ds_w[k]) : r_q[k];
    end
  end

  assign qf_w   = q_q[QB];
  assign bigp_w = |qf_w[QB-1:COORD_BITS-1];
  assign bign_w = qf_w[QB-1] | (qf_w[COORD_BITS-1] & (|qf_w[COORD_BITS-2:0]));

  always_comb begin
    if (ng_q[QB]) begin
      quo_d = bign_w ? {1'b1, {(COORD_BITS-1){1'b0}}} : -qf_w[COORD_BITS-1:0];
    end else begin
      quo_d = bigp_w ? {1'b0, {(COORD_BITS-1){1'b1}}} : {1'b0, qf_w[COORD_BITS-2:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QB; k++) vl_q[k] <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      vl_q[0] <= valid_i;
      for (int k = 0; k < QB; k++) vl_q[k+1] <= vl_q[k];
      vo_q <= vl_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0]  <= NW'({an_w, 1'b0}) + NW'(ad_w);
    d_q[0]  <= {ad_w, 1'b0};
    ng_q[0] <= num_i[NUMW-1] ^ den_i[DENW-1];
    for (int k = 0; k < QB - 1; k++) begin
      r_q[k+1] <= rn_w[k];
      d_q[k+1] <= d_q[k];
    end
    q_q[1] <= QB'(ge_w[0]);
    for (int k = 1; k < QB; k++) q_q[k+1] <= {q_q[k][QB-2:0], ge_w[k]};
    for (int k = 0; k < QB; k++) ng_q[k+1] <= ng_q[k];
    quo_q <= quo_d;
  end

  assign valid_o = vo_q;
  assign quo_o   = quo_q;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Closest-point-on-triangle testbench
// Streams queries into closest_point_on_triangle with random gaps. An exact
// wide-integer predictor computes the expected point and region of each
// accepted beat. Results are checked in order against those expectations.
// ----------------------------------------------------------------------------
module testbench;
  import cpt_pkg::*;

  typedef logic signed [191:0] wd_t;
  typedef struct {
    crd_t    nx, ny, nz;
    region_e reg_code;
  } near_t;

  class near_board;
    near_t pending[$];
    int    errors = 0;

    static function wd_t dot3(wd_t u[3], wd_t v[3]);
      return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    static function crd_t round_div(wd_t n, wd_t d);
      wd_t an, ad, q;
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      q = (2 * an + ad) / (2 * ad);
      if ((n < 0) != (d < 0)) q = -q;
      if (q > 32767) return 16'sh7fff;
      if (q < -32768) return 16'sh8000;
      return crd_t'(q);
    endfunction

    static function near_t closest(crd_t c[12]);
      wd_t p[3], a[3], b[3], cv[3], ab[3], ac[3], ap[3], bp[3], cp[3], bc[3];
      wd_t d1, d2, d3, d4, d5, d6, va, vb, vc, den, e;
      crd_t rs[3];
      near_t r;
      for (int i = 0; i < 3; i++) begin
        p[i] = c[i]; a[i] = c[3+i]; b[i] = c[6+i]; cv[i] = c[9+i];
        ab[i] = b[i] - a[i]; ac[i] = cv[i] - a[i]; ap[i] = p[i] - a[i];
        bp[i] = p[i] - b[i]; cp[i] = p[i] - cv[i]; bc[i] = cv[i] - b[i];
        rs[i] = c[3+i];
      end
      d1 = dot3(ab, ap); d2 = dot3(ac, ap); d3 = dot3(ab, bp);
      d4 = dot3(ac, bp); d5 = dot3(ab, cp); d6 = dot3(ac, cp);
      vc = d1 * d4 - d3 * d2;
      vb = d5 * d2 - d1 * d6;
      va = d3 * d6 - d5 * d4;
      if (d1 <= 0 && d2 <= 0) begin
        r.reg_code = REG_VA;
      end else if (d3 >= 0 && d4 <= d3) begin
        r.reg_code = REG_VB;
        for (int i = 0; i < 3; i++) rs[i] = c[6+i];
      end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
        r.reg_code = REG_AB;
        den = d1 - d3;
        if (den != 0)
          for (int i = 0; i < 3; i++) rs[i] = round_div(a[i] * den + ab[i] * d1, den);
      end else if (d6 >= 0 && d5 <= d6) begin
        r.reg_code = REG_VC;
        for (int i = 0; i < 3; i++) rs[i] = c[9+i];
      end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
        r.reg_code = REG_AC;
        den = d2 - d6;
        if (den != 0)
          for (int i = 0; i < 3; i++) rs[i] = round_div(a[i] * den + ac[i] * d2, den);
      end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
        r.reg_code = REG_BC;
        e = d4 - d3;
        den = e + (d5 - d6);
        for (int i = 0; i < 3; i++) rs[i] = c[6+i];
        if (den != 0)
          for (int i = 0; i < 3; i++) rs[i] = round_div(b[i] * den + bc[i] * e, den);
      end else begin
        r.reg_code = REG_FACE;
        den = va + vb + vc;
        if (den != 0)
          for (int i = 0; i < 3; i++)
            rs[i] = round_div(a[i] * den + ab[i] * vb + ac[i] * vc, den);
      end
      r.nx = rs[0]; r.ny = rs[1]; r.nz = rs[2];
      return r;
    endfunction

    function void note_query(crd_t c[12]);
      pending = {pending, closest(c)};
    endfunction

    function void check_result(near_t act);
      near_t ex;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d region=%0d",
                 $time, act.nx, act.ny, act.nz, act.reg_code);
        errors++;
        return;
      end
      ex = pending.pop_front();
      if (act.nx !== ex.nx) begin
        $display("%0t: near_x expected %0d actual %0d", $time, ex.nx, act.nx); errors++;
      end
      if (act.ny !== ex.ny) begin
        $display("%0t: near_y expected %0d actual %0d", $time, ex.ny, act.ny); errors++;
      end
      if (act.nz !== ex.nz) begin
        $display("%0t: near_z expected %0d actual %0d", $time, ex.nz, act.nz); errors++;
      end
      if (act.reg_code !== ex.reg_code) begin
        $display("%0t: region expected %0d actual %0d", $time, ex.reg_code, act.reg_code);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, done_o;
  crd_t crd [12];
  crd_t near_x_o, near_y_o, near_z_o;
  logic [2:0] region_o;
  near_board board = new();
  int idle_cycles = 0;

  closest_point_on_triangle uut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .query_x_i(crd[0]), .query_y_i(crd[1]), .query_z_i(crd[2]),
    .vert_a_x_i(crd[3]), .vert_a_y_i(crd[4]), .vert_a_z_i(crd[5]),
    .vert_b_x_i(crd[6]), .vert_b_y_i(crd[7]), .vert_b_z_i(crd[8]),
    .vert_c_x_i(crd[9]), .vert_c_y_i(crd[10]), .vert_c_z_i(crd[11]),
    .done_o, .near_x_o, .near_y_o, .near_z_o, .region_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial for (int i = 0; i < 12; i++) crd[i] = '0;

  always @(posedge clk_i) begin
    near_t act;
    logic  moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (done_o) begin
        act.nx = near_x_o; act.ny = near_y_o; act.nz = near_z_o;
        act.reg_code = region_e'(region_o);
        board.check_result(act);
        moved = 1'b1;
      end
      if (start_i && !busy_o) begin
        board.note_query(crd);
        moved = 1'b1;
      end
      if (idle_cycles > 3000) begin
        $display("CHECKS FAILED");
        $finish;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  task automatic send_query(crd_t q[12]);
    crd = q;
    start_i = 1'b1;
    while (busy_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(200, 30) : $urandom_range(3);
    if ($urandom_range(3) == 0) n = 0;
    if (n > 0) begin
      start_i = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  function automatic crd_t around(crd_t ctr, int span);
    return crd_t'(int'(ctr) + int'($urandom_range(2 * span)) - span);
  endfunction

  task automatic random_query(output crd_t q[12]);
    int mode, span;
    crd_t base;
    mode = $urandom_range(9);
    span = ($urandom_range(1)) ? 400 : 4000;
    base = crd_t'($urandom);
    for (int i = 0; i < 12; i++) begin
      if (mode < 2) q[i] = crd_t'($urandom);
      else q[i] = around(base, span);
    end
    case (mode)
      2: for (int i = 0; i < 3; i++) q[6+i] = q[3+i];
      3: for (int i = 0; i < 3; i++) q[9+i] = q[3+i];
      4: for (int i = 0; i < 3; i++) q[9+i] = q[6+i];
      5: for (int i = 0; i < 3; i++) q[9+i] = crd_t'(2 * int'(q[6+i]) - int'(q[3+i]));
      6: for (int i = 0; i < 3; i++) begin
        q[6+i] = q[3+i]; q[9+i] = q[3+i];
      end
      7: for (int i = 0; i < 12; i++)
        q[i] = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
      default: ;
    endcase
  endtask

  initial begin
    crd_t q[12];
    crd_t t[12];
    crd_t pts[7][3];
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // A at origin, B on x, C on y, query in each region
    pts = '{'{-100, -100, 0}, '{800, -10, 5}, '{-10, 800, -5}, '{320, -100, 20},
            '{-100, 320, -20}, '{400, 400, 7}, '{100, 100, 50}};
    t = '{0, 0, 0, 0, 0, 0, 640, 0, 0, 0, 640, 0};
    for (int k = 0; k < 7; k++) begin
      for (int i = 0; i < 3; i++) t[i] = pts[k][i];
      send_query(t);
    end
    // degenerate edges and zero-area face
    t = '{5, 7, 9, 10, 10, 10, 10, 10, 10, 50, 60, 70};
    send_query(t);
    t = '{30, 3, 0, 0, 0, 0, 64, 0, 0, 128, 0, 0};
    send_query(t);
    t = '{1, 2, 3, 4, 4, 4, 4, 4, 4, 4, 4, 4};
    send_query(t);
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 12; i++)
        t[i] = (((k + i) % 3) == 0) ? 16'sh7fff : (((k + i) % 3) == 1) ? 16'sh8000 : 16'sh0;
      send_query(t);
    end
    for (int i = 0; i < 12; i++) t[i] = 16'sh8000;
    send_query(t);
    for (int i = 0; i < 12; i++) t[i] = 16'sh7fff;
    send_query(t);

    for (int n = 0; n < 2000; n++) begin
      random_query(q);
      send_query(q);
      idle_gap();
      if (n == 1000) begin
        start_i = 1'b0;
        while (board.pending.size() != 0) @(negedge clk_i);
      end
    end
    start_i = 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (board.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* closest_point_on_triangle.f */
rtl/cpt_pkg.sv
rtl/cpt_div.sv
rtl/closest_point_on_triangle.sv
tb/testbench.sv
